>>> hw/rtl/mks_pkg.sv
// Shared constants, types and pass-plan functions of the multi-key record sorter.
package mks_pkg;

   localparam int MAX_RECORDS  = 16;
   localparam int NAME_BYTES   = 40;
   localparam int TOWN_BYTES   = 40;
   localparam int NAME_CHUNKS  = (NAME_BYTES + 7) / 8;
   localparam int TOWN_CHUNKS  = (TOWN_BYTES + 7) / 8;
   localparam int RESULT_LIMIT = 16;
   localparam int N_LIMIT      = (MAX_RECORDS < RESULT_LIMIT) ? MAX_RECORDS : RESULT_LIMIT;

   localparam int SLOT_W      = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int NAME_AW     = $clog2(MAX_RECORDS * NAME_CHUNKS);
   localparam int TOWN_AW     = $clog2(MAX_RECORDS * TOWN_CHUNKS);
   localparam int PASS_W      = $clog2(NAME_CHUNKS + TOWN_CHUNKS + 1);
   localparam int KEY_W       = 64;
   localparam int ID_W        = 16;
   localparam int GRADE_W     = 7;
   localparam int IDGR_W      = ID_W + GRADE_W;
   localparam int CHUNK_W     = 3;
   localparam int CFG_W       = 5;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      CMD_NAME  = 2'd0,
      CMD_TOWN  = 2'd1,
      CMD_IDGR  = 2'd2,
      CMD_SORT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KEY_NAME  = 2'd0,
      KEY_ID    = 2'd1,
      KEY_GRADE = 2'd2,
      KEY_TOWN  = 2'd3
   } key_sel_type;

   typedef enum logic [1:0] {
      SRC_NAME  = 2'd0,
      SRC_TOWN  = 2'd1,
      SRC_ID    = 2'd2,
      SRC_GRADE = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_LOAD = 2'd1,
      ST_SORT = 2'd2,
      ST_EMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic shift_slot;
      logic shift_key;
      logic pair_left;
      logic pair_right;
   } cell_ctl_type;

   // Number of stable passes, least significant key part first.
   function automatic logic [PASS_W-1:0] pass_count(input key_sel_type k);
      int c;
      case (k)
         KEY_ID:    c = 1;
         KEY_GRADE: c = NAME_CHUNKS + 1;
         KEY_TOWN:  c = NAME_CHUNKS + TOWN_CHUNKS;
         default:   c = NAME_CHUNKS;
      endcase
      return PASS_W'(c);
   endfunction

   function automatic src_type pass_src(input key_sel_type k, input logic [PASS_W-1:0] p);
      src_type s;
      if (k == KEY_ID) s = SRC_ID;
      else if (int'(p) < NAME_CHUNKS) s = SRC_NAME;
      else if (k == KEY_GRADE) s = SRC_GRADE;
      else s = SRC_TOWN;
      return s;
   endfunction

   function automatic logic [CHUNK_W-1:0] pass_chunk(input logic [PASS_W-1:0] p);
      int c;
      if (int'(p) < NAME_CHUNKS) c = NAME_CHUNKS - 1 - int'(p);
      else c = TOWN_CHUNKS - 1 - (int'(p) - NAME_CHUNKS);
      return CHUNK_W'(c);
   endfunction

endpackage

>>> hw/rtl/mks_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/mks_cell.sv
// One sorter cell: holds one order entry and its current key part.
module mks_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mks_pkg::cell_ctl_type        ctl,
   input  logic [mks_pkg::SLOT_W-1:0]   reset_slot,
   input  logic [mks_pkg::SLOT_W-1:0]   r_slot,
   input  logic [mks_pkg::KEY_W-1:0]    r_key,
   input  logic [mks_pkg::SLOT_W-1:0]   l_slot,
   input  logic [mks_pkg::KEY_W-1:0]    l_key,
   input  logic                         l_gt,
   output logic [mks_pkg::SLOT_W-1:0]   slot,
   output logic [mks_pkg::KEY_W-1:0]    key,
   output logic                         gt
);
   import mks_pkg::*;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   // strict compare keeps ties in place
   assign gt = key_ff > r_key;

   always_comb begin
      slot_in = slot_ff;
      key_in  = key_ff;
      if (ctl.shift_slot) slot_in = r_slot;
      if (ctl.shift_key) key_in = r_key;
      if (ctl.pair_left && gt) begin
         slot_in = r_slot;
         key_in  = r_key;
      end else if (ctl.pair_right && l_gt) begin
         slot_in = l_slot;
         key_in  = l_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= reset_slot;
      else slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign slot = slot_ff;
   assign key  = key_ff;
endmodule

>>> hw/rtl/multi_key_record_sorter.sv
// Top level of the multi-key record sorter: record stores, cell chain and sequencer.
//
//  channel | dir | handshake              | contents
//  req     | in  | req_tvalid/req_tready  | tuser cmd, tdata record fields / sort key
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata position, slot; tlast on final word
//  csr     | in  | csr_valid/csr_ready    | records_in_use (always ready)
//
// A sort word runs one stable pass per key part, least significant part first:
// name 5 passes, id 1, grade 6, town 10. Each pass is a rotation of the chain
// through the store read port, then MAX_RECORDS odd-even exchange phases;
// then n result words follow, one per cycle unless rsp_tready stalls them.
// reset is synchronous; it restores the identity order and records_in_use 10.
// req_tready is low from a sort word until its last result is loaded.
module multi_key_record_sorter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] slot, [6:4] chunk_index, [70:7] chunk_data, [86:71] record_id,
   // [93:87] grade_code, [95:94] sort_key
   input  logic [mks_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] position, [7:4] slot_at_position
   output logic [mks_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mks_pkg::CFG_W-1:0]          csr_data
);
   import mks_pkg::*;

   // unpack the request word
   logic [3:0]         f_slot;
   logic [CHUNK_W-1:0] f_chunk;
   logic [KEY_W-1:0]   f_data;
   logic [ID_W-1:0]    f_id;
   logic [GRADE_W-1:0] f_grade;
   key_sel_type        f_key;
   cmd_type            f_cmd;

   assign f_slot  = req_tdata[3:0];
   assign f_chunk = req_tdata[6:4];
   assign f_data  = req_tdata[70:7];
   assign f_id    = req_tdata[86:71];
   assign f_grade = req_tdata[93:87];
   assign f_key   = key_sel_type'(req_tdata[95:94]);
   assign f_cmd   = cmd_type'(req_tuser);

   // configuration register
   logic [CFG_W-1:0] riu_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) riu_ff <= CFG_W'(10);
      else if (csr_valid) riu_ff <= csr_data;
   end

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   key_sel_type       key_sel_ff, key_sel_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic req_fire, sort_start, slot_ok, emit_load, load_end, phase_end, pass_last;
   logic [CFG_W-1:0] n_raw;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign sort_start = req_fire && (f_cmd == CMD_SORT);
   assign slot_ok    = int'(f_slot) < MAX_RECORDS;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign load_end   = step_ff == CNT_W'(MAX_RECORDS);
   assign phase_end  = step_ff == CNT_W'(MAX_RECORDS - 1);
   assign pass_last  = pass_ff == pass_count(key_sel_ff) - PASS_W'(1);

   // clamp records in use to 1..N_LIMIT
   always_comb begin
      n_raw = (riu_ff == '0) ? CFG_W'(1) : riu_ff;
      if (n_raw > CFG_W'(N_LIMIT)) n_raw = CFG_W'(N_LIMIT);
   end

   // record stores
   logic [SLOT_W-1:0]  cell_slot [MAX_RECORDS];
   logic [KEY_W-1:0]   cell_key  [MAX_RECORDS];
   logic               cell_gt   [MAX_RECORDS];
   cell_ctl_type       cell_ctl  [MAX_RECORDS];

   src_type            cur_src;
   logic [CHUNK_W-1:0] cur_chunk;
   logic [KEY_W-1:0]   name_rd, town_rd, load_key;
   logic [IDGR_W-1:0]  idgr_rd;
   logic               name_we, town_we, idgr_we;
   logic [SLOT_W-1:0]  wr_slot;

   assign cur_src   = pass_src(key_sel_ff, pass_ff);
   assign cur_chunk = pass_chunk(pass_ff);
   assign wr_slot   = SLOT_W'(f_slot);
   assign name_we   = req_fire && (f_cmd == CMD_NAME) && slot_ok && int'(f_chunk) < NAME_CHUNKS;
   assign town_we   = req_fire && (f_cmd == CMD_TOWN) && slot_ok && int'(f_chunk) < TOWN_CHUNKS;
   assign idgr_we   = req_fire && (f_cmd == CMD_IDGR) && slot_ok;

   mks_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS * NAME_CHUNKS)) u_name_ram (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (NAME_AW'(int'(wr_slot) * NAME_CHUNKS + int'(f_chunk))),
      .wr_data (f_data),
      .rd_addr (NAME_AW'(int'(cell_slot[0]) * NAME_CHUNKS + int'(cur_chunk))),
      .rd_data (name_rd)
   );

   mks_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS * TOWN_CHUNKS)) u_town_ram (
      .clock   (clock),
      .wr_en   (town_we),
      .wr_addr (TOWN_AW'(int'(wr_slot) * TOWN_CHUNKS + int'(f_chunk))),
      .wr_data (f_data),
      .rd_addr (TOWN_AW'(int'(cell_slot[0]) * TOWN_CHUNKS + int'(cur_chunk))),
      .rd_data (town_rd)
   );

   mks_ram #(.WIDTH(IDGR_W), .DEPTH(MAX_RECORDS)) u_idgr_ram (
      .clock   (clock),
      .wr_en   (idgr_we),
      .wr_addr (wr_slot),
      .wr_data ({f_grade, f_id}),
      .rd_addr (cell_slot[0]),
      .rd_data (idgr_rd)
   );

   // pick the key part of the current pass from the read port
   always_comb begin
      case (cur_src)
         SRC_NAME:  load_key = name_rd;
         SRC_TOWN:  load_key = town_rd;
         SRC_ID:    load_key = KEY_W'(idgr_rd[ID_W-1:0]);
         SRC_GRADE: load_key = KEY_W'(idgr_rd[IDGR_W-1:ID_W]);
         default:   load_key = name_rd;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (sort_start) state_in = ST_LOAD;
         ST_LOAD: if (load_end) state_in = ST_SORT;
         ST_SORT: begin
            if (phase_end) state_in = pass_last ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: if (emit_load && (out_cnt_ff + CNT_W'(1) == n_ff)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // counters and result register
   always_comb begin
      step_in      = step_ff;
      pass_in      = pass_ff;
      key_sel_in   = key_sel_ff;
      n_in         = n_ff;
      out_cnt_in   = out_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in    = '0;
            pass_in    = '0;
            out_cnt_in = '0;
            if (sort_start) begin
               key_sel_in = f_key;
               n_in       = CNT_W'(n_raw);
            end
         end
         ST_LOAD: begin
            step_in = load_end ? '0 : step_ff + CNT_W'(1);
         end
         ST_SORT: begin
            step_in = phase_end ? '0 : step_ff + CNT_W'(1);
            if (phase_end) pass_in = pass_ff + PASS_W'(1);
         end
         ST_EMIT: begin
            if (emit_load) begin
               out_cnt_in   = out_cnt_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'(cell_slot[out_cnt_ff[SLOT_W-1:0]]), 4'(out_cnt_ff)};
               rsp_last_in  = (out_cnt_ff + CNT_W'(1) == n_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pass_ff      <= '0;
         key_sel_ff   <= KEY_NAME;
         n_ff         <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         key_sel_ff   <= key_sel_in;
         n_ff         <= n_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // cell chain: rotate slots through the read port while loading, then
   // run odd-even exchange phases; cells at or past n never take part
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic [SLOT_W-1:0] r_slot, l_slot;
      logic [KEY_W-1:0]  r_key, l_key;
      logic              l_gt;

      if (i == MAX_RECORDS - 1) begin : g_tail
         // wrap the slot back around, take the fresh key from the store
         assign r_slot = cell_slot[0];
         assign r_key  = load_key;
         assign cell_ctl[i].pair_left = 1'b0;
      end else begin : g_body
         assign r_slot = cell_slot[i+1];
         assign r_key  = cell_key[i+1];
         assign cell_ctl[i].pair_left = (state_ff == ST_SORT) && (step_ff[0] == 1'(i % 2))
                                        && (CNT_W'(i + 1) < n_ff);
      end

      if (i == 0) begin : g_head
         assign l_slot = cell_slot[0];
         assign l_key  = cell_key[0];
         assign l_gt   = 1'b0;
         assign cell_ctl[i].pair_right = 1'b0;
      end else begin : g_left
         assign l_slot = cell_slot[i-1];
         assign l_key  = cell_key[i-1];
         assign l_gt   = cell_gt[i-1];
         assign cell_ctl[i].pair_right = (state_ff == ST_SORT)
                                         && (step_ff[0] == 1'((i - 1) % 2))
                                         && (CNT_W'(i) < n_ff);
      end

      // keys shift in the cycle after the slots, to meet the registered read data
      assign cell_ctl[i].shift_slot = (state_ff == ST_LOAD) && !load_end;
      assign cell_ctl[i].shift_key  = (state_ff == ST_LOAD) && (step_ff != '0);

      mks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .reset_slot (SLOT_W'(i)),
         .r_slot     (r_slot),
         .r_key      (r_key),
         .l_slot     (l_slot),
         .l_key      (l_key),
         .l_gt       (l_gt),
         .slot       (cell_slot[i]),
         .key        (cell_key[i]),
         .gt         (cell_gt[i])
      );
   end
endmodule
